// ===== hw/rtl/fca_pkg.sv =====
`default_nettype none
package fca_pkg;

  // Operation codes
  localparam logic [1:0] OP_READ  = 2'd0;
  localparam logic [1:0] OP_WRITE = 2'd1;
  localparam logic [1:0] OP_ALLOC = 2'd2;
  localparam logic [1:0] OP_FREE  = 2'd3;

  // Status codes
  localparam logic [1:0] ST_OK     = 2'd0;
  localparam logic [1:0] ST_FULL   = 2'd1;
  localparam logic [1:0] ST_RANGE  = 2'd2;
  localparam logic [1:0] ST_BROKEN = 2'd3;

  // Register indexes
  localparam logic [1:0] REG_END_MARKER = 2'd0;
  localparam logic [1:0] REG_RSVD_ZERO  = 2'd1;
  localparam logic [1:0] REG_RSVD_ONE   = 2'd2;

  localparam logic [31:0] END_MARKER_RST = 32'h0FFF_FFFF;
  localparam logic [31:0] RSVD_ZERO_RST  = 32'h0FFF_FFF8;
  localparam logic [31:0] RSVD_ONE_RST   = 32'h0FFF_FFFF;

  // First entry that can belong to a chain
  localparam int unsigned FIRST_DATA = 3;

  typedef struct packed {
    logic [1:0]  op;
    logic [8:0]  cluster;
    logic [31:0] entry_value;
    logic [30:0] byte_count;
  } cmd_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [31:0] result_value;
    logic [9:0]  clusters_changed;
  } rsp_t;

  typedef struct packed {
    logic [31:0] end_marker;
    logic [31:0] rsvd_zero;
    logic [31:0] rsvd_one;
  } cfg_regs_t;

  // Table write requested by a register write (entry 0 or entry 1)
  typedef struct packed {
    logic        en;
    logic        entry;
    logic [31:0] data;
  } cfg_wr_t;

endpackage
`default_nettype wire

// ===== hw/rtl/fca_ram.sv =====
`default_nettype none
module fca_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 512
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

// ===== hw/rtl/fca_cfg.sv =====
`default_nettype none
module fca_cfg (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [3:0]        paddr,
  input  wire logic [31:0]       pwdata,
  output logic      [31:0]       prdata,
  output logic                   pready,
  output fca_pkg::cfg_regs_t     regs,
  output fca_pkg::cfg_wr_t       tbl_wr
);
  import fca_pkg::*;

  logic       wr_en;
  logic [1:0] idx;

  assign pready = 1'b1;
  assign idx    = paddr[3:2];
  assign wr_en  = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      regs.end_marker <= END_MARKER_RST;
      regs.rsvd_zero  <= RSVD_ZERO_RST;
      regs.rsvd_one   <= RSVD_ONE_RST;
    end else if (wr_en) begin
      unique case (idx)
        REG_END_MARKER: regs.end_marker <= pwdata;
        REG_RSVD_ZERO:  regs.rsvd_zero  <= pwdata;
        REG_RSVD_ONE:   regs.rsvd_one   <= pwdata;
        default: ;
      endcase
    end
  end

  // The reserved registers also load table entries 0 and 1.
  always_comb begin
    tbl_wr.en    = wr_en && (idx == REG_RSVD_ZERO || idx == REG_RSVD_ONE);
    tbl_wr.entry = (idx == REG_RSVD_ONE);
    tbl_wr.data  = pwdata;
  end

  always_comb begin
    unique case (idx)
      REG_END_MARKER: prdata = regs.end_marker;
      REG_RSVD_ZERO:  prdata = regs.rsvd_zero;
      REG_RSVD_ONE:   prdata = regs.rsvd_one;
      default:        prdata = '0;
    endcase
  end

endmodule
`default_nettype wire

// ===== hw/rtl/fat_cluster_chain_allocator.sv =====
`default_nettype none
// Read and write entry: an accepted transaction passes S_DECODE and S_RD_WAIT, and
// the strobe is registered with the table read data. Allocate: S_A_CMP checks the
// free count, then S_A_RD and S_A_CHK per entry scanned, S_A_LINK per cluster taken.
// Free: S_F_RD and S_F_CHK per link walked. One operation at a time; the link table
// has a single read port with registered read data. After reset a clearing pass over
// all TABLE_ENTRIES entries keeps busy high; the receiver cannot stall results.
module fat_cluster_chain_allocator #(
  parameter int TABLE_ENTRIES = 512,
  parameter int CLUSTER_BYTES = 2048
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          start,
  output logic               busy,
  input  wire fca_pkg::cmd_t cmd,
  output logic               done,
  output fca_pkg::rsp_t      rsp,
  input  wire logic          psel,
  input  wire logic          penable,
  input  wire logic          pwrite,
  input  wire logic [3:0]    paddr,
  input  wire logic [31:0]   pwdata,
  output logic      [31:0]   prdata,
  output logic               pready
);
  import fca_pkg::*;

  localparam int IW = $clog2(TABLE_ENTRIES);
  localparam int CW = $clog2(TABLE_ENTRIES + 1);

  // One-hot sequencer states.
  typedef enum logic [9:0] {
    S_IDLE    = 10'b00_0000_0001,
    S_DECODE  = 10'b00_0000_0010,
    S_RD_WAIT = 10'b00_0000_0100,
    S_A_CMP   = 10'b00_0000_1000,
    S_A_RD    = 10'b00_0001_0000,
    S_A_CHK   = 10'b00_0010_0000,
    S_A_LINK  = 10'b00_0100_0000,
    S_F_RD    = 10'b00_1000_0000,
    S_F_CHK   = 10'b01_0000_0000,
    S_UNUSED  = 10'b10_0000_0000
  } state_t;

  state_t state;

  cfg_regs_t regs;
  cfg_wr_t   cfg_wr;

  fca_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .regs    (regs),
    .tbl_wr  (cfg_wr)
  );

  // Link table memory and its single write port mux.
  logic          ram_we;
  logic [IW-1:0] ram_waddr;
  logic [31:0]   ram_wdata;
  logic [IW-1:0] ram_raddr;
  logic [31:0]   rdata;

  fca_ram #(.WIDTH(32), .DEPTH(TABLE_ENTRIES)) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (rdata)
  );

  // Clearing pass after reset.
  logic          sweeping;
  logic [CW-1:0] sweep_idx;
  logic [31:0]   sweep_val;

  // Operation registers.
  cmd_t          cmd_q;
  logic [CW-1:0] free_cnt;
  logic [CW-1:0] scan;
  logic [CW-1:0] steps;
  logic [CW-1:0] chg;
  logic [IW-1:0] prev;
  logic [IW-1:0] cur;
  logic          have_prev;
  logic [31:0]   head;
  logic [30:0]   rem;
  logic [47:0]   prod;

  logic          fsm_we;
  logic [IW-1:0] fsm_waddr;
  logic [31:0]   fsm_wdata;

  logic [IW-1:0] cl_idx;
  logic          cl_oor;
  logic          link_ok;
  logic          is_end;
  logic          full;

  assign busy    = (state != S_IDLE) || sweeping;
  assign cl_idx  = IW'(32'(cmd_q.cluster));
  assign cl_oor  = 32'(cmd_q.cluster) >= 32'(TABLE_ENTRIES);
  assign is_end  = (rdata == regs.end_marker);
  assign link_ok = (rdata >= 32'(FIRST_DATA)) && (rdata < 32'(TABLE_ENTRIES));
  // A request needs more clusters than are free exactly when the byte count
  // exceeds free_cnt whole clusters; a zero count needs one.
  assign full    = (cmd_q.byte_count == '0) ? (free_cnt == '0)
                                            : ({17'b0, cmd_q.byte_count} > prod);

  always_comb begin
    if (sweep_idx == CW'(0)) begin
      sweep_val = regs.rsvd_zero;
    end else if (sweep_idx == CW'(1)) begin
      sweep_val = regs.rsvd_one;
    end else if (sweep_idx == CW'(2)) begin
      sweep_val = END_MARKER_RST;
    end else begin
      sweep_val = '0;
    end
  end

  // Sequencer accesses to the table.
  always_comb begin
    fsm_we    = 1'b0;
    fsm_waddr = cur;
    fsm_wdata = '0;
    ram_raddr = cl_idx;
    unique case (state)
      S_RD_WAIT: begin
        fsm_we    = (cmd_q.op == OP_WRITE);
        fsm_waddr = cl_idx;
        fsm_wdata = cmd_q.entry_value;
      end
      S_A_RD: ram_raddr = scan[IW-1:0];
      S_A_CHK: begin
        // Link the previous cluster of the chain to this one.
        fsm_we    = (rdata == '0) && have_prev;
        fsm_waddr = prev;
        fsm_wdata = 32'(scan);
      end
      S_A_LINK: begin
        fsm_we    = 1'b1;
        fsm_waddr = scan[IW-1:0];
        fsm_wdata = regs.end_marker;
      end
      S_F_RD: ram_raddr = cur;
      S_F_CHK: begin
        fsm_we    = is_end || link_ok;
        fsm_waddr = cur;
        fsm_wdata = '0;
      end
      default: ;
    endcase
  end

  // Register writes take precedence; the clearing pass waits for them.
  always_comb begin
    priority if (cfg_wr.en) begin
      ram_we    = 1'b1;
      ram_waddr = IW'(cfg_wr.entry);
      ram_wdata = cfg_wr.data;
    end else if (sweeping) begin
      ram_we    = 1'b1;
      ram_waddr = sweep_idx[IW-1:0];
      ram_wdata = sweep_val;
    end else begin
      ram_we    = fsm_we;
      ram_waddr = fsm_waddr;
      ram_wdata = fsm_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      done      <= 1'b0;
      sweeping  <= 1'b1;
      sweep_idx <= '0;
      free_cnt  <= CW'(TABLE_ENTRIES - FIRST_DATA);
    end else begin
      done <= 1'b0;
      if (sweeping && !cfg_wr.en) begin
        sweep_idx <= sweep_idx + CW'(1);
        if (sweep_idx == CW'(TABLE_ENTRIES - 1)) begin
          sweeping <= 1'b0;
        end
      end
      unique case (state)
        S_IDLE: begin
          if (start && !busy) begin
            cmd_q <= cmd;
            state <= S_DECODE;
          end
        end
        S_DECODE: begin
          chg       <= '0;
          steps     <= '0;
          have_prev <= 1'b0;
          head      <= '0;
          scan      <= CW'(FIRST_DATA);
          cur       <= cl_idx;
          rem       <= cmd_q.byte_count;
          prod      <= 48'(free_cnt) * 48'(CLUSTER_BYTES);
          unique case (cmd_q.op)
            OP_READ, OP_WRITE: begin
              if (cl_oor) begin
                done  <= 1'b1;
                rsp   <= '{status: ST_RANGE, result_value: '0, clusters_changed: '0};
                state <= S_IDLE;
              end else begin
                state <= S_RD_WAIT;
              end
            end
            OP_ALLOC: state <= S_A_CMP;
            default: begin
              if (cl_oor || 32'(cmd_q.cluster) < 32'(FIRST_DATA)) begin
                done  <= 1'b1;
                rsp   <= '{status: ST_RANGE, result_value: '0, clusters_changed: '0};
                state <= S_IDLE;
              end else begin
                state <= S_F_RD;
              end
            end
          endcase
        end
        S_RD_WAIT: begin
          done  <= 1'b1;
          state <= S_IDLE;
          if (cmd_q.op == OP_READ) begin
            rsp <= '{status: ST_OK, result_value: rdata, clusters_changed: '0};
          end else begin
            rsp <= '{status: ST_OK, result_value: '0, clusters_changed: '0};
            if (32'(cmd_q.cluster) >= 32'(FIRST_DATA)) begin
              if (rdata == '0 && cmd_q.entry_value != '0) begin
                free_cnt <= free_cnt - CW'(1);
              end else if (rdata != '0 && cmd_q.entry_value == '0) begin
                free_cnt <= free_cnt + CW'(1);
              end
            end
          end
        end
        S_A_CMP: begin
          if (full) begin
            done  <= 1'b1;
            rsp   <= '{status: ST_FULL, result_value: '0, clusters_changed: '0};
            state <= S_IDLE;
          end else begin
            state <= S_A_RD;
          end
        end
        S_A_RD: begin
          if (scan >= CW'(TABLE_ENTRIES)) begin
            done  <= 1'b1;
            rsp   <= '{status: ST_OK, result_value: head, clusters_changed: 10'(chg)};
            state <= S_IDLE;
          end else begin
            state <= S_A_CHK;
          end
        end
        S_A_CHK: begin
          if (rdata == '0) begin
            // The previous cluster held the end marker; a zero marker left it free.
            if (have_prev && regs.end_marker == '0) begin
              free_cnt <= free_cnt - CW'(1);
            end
            state <= S_A_LINK;
          end else begin
            scan  <= scan + CW'(1);
            state <= S_A_RD;
          end
        end
        S_A_LINK: begin
          logic [31:0] head_n;
          logic [CW-1:0] chg_n;
          head_n = have_prev ? head : 32'(scan);
          chg_n  = chg + CW'(1);
          if (regs.end_marker != '0) begin
            free_cnt <= free_cnt - CW'(1);
          end
          head      <= head_n;
          chg       <= chg_n;
          have_prev <= 1'b1;
          prev      <= scan[IW-1:0];
          scan      <= scan + CW'(1);
          if (rem <= 31'(CLUSTER_BYTES)) begin
            done  <= 1'b1;
            rsp   <= '{status: ST_OK, result_value: head_n, clusters_changed: 10'(chg_n)};
            state <= S_IDLE;
          end else begin
            rem   <= rem - 31'(CLUSTER_BYTES);
            state <= S_A_RD;
          end
        end
        S_F_RD: begin
          if (steps >= CW'(TABLE_ENTRIES)) begin
            done  <= 1'b1;
            rsp   <= '{status: ST_BROKEN, result_value: '0, clusters_changed: 10'(chg)};
            state <= S_IDLE;
          end else begin
            state <= S_F_CHK;
          end
        end
        S_F_CHK: begin
          if (is_end) begin
            if (rdata != '0) begin
              free_cnt <= free_cnt + CW'(1);
            end
            done  <= 1'b1;
            rsp   <= '{status: ST_OK, result_value: '0,
                       clusters_changed: 10'(chg + CW'(1))};
            state <= S_IDLE;
          end else if (!link_ok) begin
            done  <= 1'b1;
            rsp   <= '{status: ST_BROKEN, result_value: '0, clusters_changed: 10'(chg)};
            state <= S_IDLE;
          end else begin
            free_cnt <= free_cnt + CW'(1);
            chg      <= chg + CW'(1);
            steps    <= steps + CW'(1);
            cur      <= IW'(rdata);
            state    <= S_F_RD;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule
`default_nettype wire

// ===== hw/rtl/fca_checker.sv =====
`default_nettype none
module fca_checker (
  input wire logic          clk,
  input wire logic          rst,
  input wire logic          start,
  input wire logic          busy,
  input wire logic          done,
  input wire fca_pkg::rsp_t rsp
);
  import fca_pkg::*;

  // A result only follows work in progress.
  a_done_after_busy: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(busy)) else $error("result without a transaction in progress");

  // Once a result is shown the block is free again.
  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy) else $error("busy while a result is shown");

  // Each result is registered in S_DECODE or a later state, never in S_IDLE, so strobes never touch.
  a_done_single: assert property (@(posedge clk) disable iff (rst)
    done |=> !done) else $error("back-to-back result strobes");

  // An accepted transaction keeps the block busy in the next cycle.
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    start && !busy |=> busy) else $error("accepted transaction not started");

  // A refused allocation changes nothing.
  a_full_empty: assert property (@(posedge clk) disable iff (rst)
    done && rsp.status == ST_FULL |-> rsp.result_value == '0 && rsp.clusters_changed == '0)
    else $error("table full result carries data");

endmodule

bind fat_cluster_chain_allocator fca_checker u_fca_checker (
  .clk   (clk),
  .rst   (rst),
  .start (start),
  .busy  (busy),
  .done  (done),
  .rsp   (rsp)
);
`default_nettype wire
